/* sv/qrs_pkg.sv */
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared types, codes and helpers for the quadratic root solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

  localparam int OUT_WIDTH     = 32;
  localparam int OUT_FRAC_BITS = 16;
  localparam int QUO_EXT_W     = 64;

  typedef enum logic [1:0] {
    KIND_TWO    = 2'd0,
    KIND_DOUBLE = 2'd1,
    KIND_NONE   = 2'd2,
    KIND_DEGEN  = 2'd3
  } root_kind_e;

  typedef struct packed {
    logic                 sat;
    logic [OUT_WIDTH-1:0] value;
  } root_res_t;

  // Apply sign to an unsigned quotient magnitude and clip to the Q16.16 range.
  function automatic root_res_t clip_root(input logic [QUO_EXT_W-1:0] quo,
                                          input logic                 neg);
    root_res_t res;
    logic [QUO_EXT_W-1:0] neg_q;
    res   = '0;
    neg_q = -quo;
    if (!neg) begin
      if (quo > QUO_EXT_W'(33'h0_7FFF_FFFF)) begin
        res.value = 32'h7FFF_FFFF;
        res.sat   = 1'b1;
      end else begin
        res.value = quo[OUT_WIDTH-1:0];
      end
    end else begin
      if (quo > QUO_EXT_W'(33'h0_8000_0000)) begin
        res.value = 32'h8000_0000;
        res.sat   = 1'b1;
      end else begin
        res.value = neg_q[OUT_WIDTH-1:0];
      end
    end
    return res;
  endfunction

endpackage

/* sv/qrs_sqrt_pipe.sv */
// ----------------------------------------------------------------------------
// qrs_sqrt_pipe
// Floor integer square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module qrs_sqrt_pipe #(
  parameter int RAD_W  = 34,
  parameter int ROOT_W = 17
) (
  input  logic              clk_i,
  input  logic              ce_i,
  input  logic [RAD_W-1:0]  rad_i,
  output logic [ROOT_W-1:0] root_o
);

  logic [RAD_W-1:0]  rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_st
    localparam int BIT = ROOT_W - 1 - k;
    logic [RAD_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [RAD_W:0]    trial;

    if (k == 0) begin : g_first
      assign rem_in  = rad_i;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    // (r + 2^i)^2 - r^2 = r*2^(i+1) + 4^i
    assign trial = ({1'b0, RAD_W'(root_in)} << (BIT + 1))
                 + ({{RAD_W{1'b0}}, 1'b1} << (2 * BIT));

    always_ff @(posedge clk_i) begin
      if (ce_i) begin
        if ({1'b0, rem_in} >= trial) begin
          rem_q[k]  <= rem_in - trial[RAD_W-1:0];
          root_q[k] <= root_in | (ROOT_W'(1) << BIT);
        end else begin
          rem_q[k]  <= rem_in;
          root_q[k] <= root_in;
        end
      end
    end
  end

  assign root_o = root_q[ROOT_W-1];

endmodule

/* sv/qrs_div_pipe.sv */
// ----------------------------------------------------------------------------
// qrs_div_pipe
// Restoring divider for (num << 16) / den, one quotient bit per stage.
// ----------------------------------------------------------------------------
module qrs_div_pipe import qrs_pkg::*; #(
  parameter int NUM_W = 19,
  parameter int DEN_W = 17
) (
  input  logic                             clk_i,
  input  logic                             ce_i,
  input  logic [NUM_W-1:0]                 num_i,
  input  logic [DEN_W-1:0]                 den_i,
  output logic [NUM_W+OUT_FRAC_BITS-1:0]   quo_o
);

  localparam int QW = NUM_W + OUT_FRAC_BITS;

  logic [DEN_W-1:0] rem_q [QW];
  logic [QW-1:0]    xq_q  [QW];
  logic [DEN_W-1:0] den_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_st
    logic [DEN_W-1:0] rem_in;
    logic [QW-1:0]    xq_in;
    logic [DEN_W-1:0] den_in;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign xq_in  = {num_i, {OUT_FRAC_BITS{1'b0}}};
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign xq_in  = xq_q[k-1];
      assign den_in = den_q[k-1];
    end

    // dividend bits shift out the top, quotient bits shift in the bottom
    assign trial = {rem_in, xq_in[QW-1]};
    assign diff  = trial - {1'b0, den_in};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      if (ce_i) begin
        rem_q[k] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        xq_q[k]  <= {xq_in[QW-2:0], ge};
        den_q[k] <= den_in;
      end
    end
  end

  assign quo_o = xq_q[QW-1];

endmodule

/* sv/quadratic_root_solver_top.sv */
// ----------------------------------------------------------------------------
// quadratic_root_solver_top
// Real roots of a*x^2 + b*x + c: exact discriminant, floor square root,
// two truncating divides, Q16.16 results with saturation.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | word
//  --------+-----------+-------------------------+--------------------------------
//  in      | sink      | in_valid_i / in_stall_o | coef_a_i, coef_b_i, coef_c_i
//  out     | source    | out_valid_o/out_stall_i | root_kind_o, root_first_o,
//          |           |                         | root_second_o, saturated_o
//
//  One word per cycle unless the pipeline holds. Stages: products, discriminant,
//  bit-per-stage square root (SW stages), numerator, divider (XW stages), output.
//  The pipeline only holds when its last stage is full and the output
//  register is full and stalled; interior bubbles do not block intake.
//  Reset clears the valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
module quadratic_root_solver_top import qrs_pkg::*; #(
  parameter int COEF_WIDTH = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [COEF_WIDTH-1:0] coef_a_i,
  input  logic signed [COEF_WIDTH-1:0] coef_b_i,
  input  logic signed [COEF_WIDTH-1:0] coef_c_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  root_kind_o,
  output logic signed [OUT_WIDTH-1:0] root_first_o,
  output logic signed [OUT_WIDTH-1:0] root_second_o,
  output logic                        saturated_o
);

  localparam int W   = COEF_WIDTH;
  localparam int DW  = (2 * W + 2 > 64) ? 64 : 2 * W + 2;
  localparam int SW  = DW / 2;
  localparam int NW  = ((W + 1 > SW + 1) ? W + 1 : SW + 1) + 1;
  localparam int XW  = NW + OUT_FRAC_BITS;
  localparam int N   = SW + XW + 3;
  localparam int SQW = 2 + W + W + 1;   // kind, a, -b
  localparam int DVW = 2 + 1 + 1;       // kind, neg first, neg second

  // ---- pipeline control ----
  logic [N-1:0] vld_q;
  logic         v_last;
  logic         out_ld;
  logic         ce;
  logic         out_valid_q, out_valid_d;

  assign v_last = vld_q[N-1];
  assign out_ld = v_last & (~out_valid_q | ~out_stall_i);
  assign ce     = ~v_last | out_ld;
  assign in_stall_o = ~ce;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ce) begin
      vld_q <= {vld_q[N-2:0], in_valid_i};
    end
  end

  always_comb begin
    if (out_ld) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // ---- stage 0: products ----
  logic signed [W-1:0]   a0_q, b0_q;
  logic signed [2*W-1:0] bb0_q, ac0_q;

  always_ff @(posedge clk_i) begin
    if (ce) begin
      a0_q  <= coef_a_i;
      b0_q  <= coef_b_i;
      bb0_q <= coef_b_i * coef_b_i;
      ac0_q <= coef_a_i * coef_c_i;
    end
  end

  // ---- stage 1: discriminant and class ----
  logic signed [DW-1:0] bb_x, ac_x, disc;
  logic signed [W:0]    nb_c;
  root_kind_e           kind_c;
  logic [DW-1:0]        d1_q;
  root_kind_e           kind1_q;
  logic signed [W-1:0]  a1_q;
  logic signed [W:0]    nb1_q;

  assign bb_x = DW'(bb0_q);
  assign ac_x = DW'(ac0_q);
  assign disc = bb_x - (ac_x <<< 2);
  assign nb_c = -($signed({b0_q[W-1], b0_q}));

  always_comb begin
    priority if (a0_q == '0) begin
      kind_c = KIND_DEGEN;
    end else if (disc == '0) begin
      kind_c = KIND_DOUBLE;
    end else if (disc[DW-1]) begin
      kind_c = KIND_NONE;
    end else begin
      kind_c = KIND_TWO;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      d1_q    <= disc;
      kind1_q <= kind_c;
      a1_q    <= a0_q;
      nb1_q   <= nb_c;
    end
  end

  // ---- square root stages ----
  logic [SW-1:0]  root_s;
  logic [SQW-1:0] sq_side_q [SW];

  qrs_sqrt_pipe #(
    .RAD_W  (DW),
    .ROOT_W (SW)
  ) u_sqrt (
    .clk_i  (clk_i),
    .ce_i   (ce),
    .rad_i  (d1_q),
    .root_o (root_s)
  );

  always_ff @(posedge clk_i) begin
    if (ce) begin
      sq_side_q[0] <= {kind1_q, a1_q, nb1_q};
      for (int k = 1; k < SW; k++) begin
        sq_side_q[k] <= sq_side_q[k-1];
      end
    end
  end

  // ---- numerator stage ----
  logic [1:0]           kind_s;
  logic signed [W-1:0]  a_s;
  logic signed [W:0]    nb_s;
  logic signed [NW-1:0] nb_x, s_x, n1, n2;
  logic [NW-1:0]        m1_c, m2_c;
  logic [W-1:0]         amag;
  logic [NW-1:0]        m1_q, m2_q;
  logic [W:0]           den_q;
  logic [DVW-1:0]       num_side_q;

  assign kind_s = sq_side_q[SW-1][SQW-1 -: 2];
  assign a_s    = $signed(sq_side_q[SW-1][2*W : W+1]);
  assign nb_s   = $signed(sq_side_q[SW-1][W:0]);

  assign nb_x = NW'(nb_s);
  assign s_x  = $signed({{(NW-SW){1'b0}}, root_s});
  assign n1   = nb_x - s_x;
  assign n2   = nb_x + s_x;
  assign m1_c = n1[NW-1] ? NW'(-n1) : NW'(n1);
  assign m2_c = n2[NW-1] ? NW'(-n2) : NW'(n2);
  assign amag = a_s[W-1] ? W'(-a_s) : W'(a_s);

  always_ff @(posedge clk_i) begin
    if (ce) begin
      m1_q       <= m1_c;
      m2_q       <= m2_c;
      den_q      <= {amag, 1'b0};
      num_side_q <= {kind_s, n1[NW-1] ^ a_s[W-1], n2[NW-1] ^ a_s[W-1]};
    end
  end

  // ---- divider stages ----
  logic [XW-1:0]  quo1, quo2;
  logic [DVW-1:0] dv_side_q [XW];

  qrs_div_pipe #(
    .NUM_W (NW),
    .DEN_W (W + 1)
  ) u_div_first (
    .clk_i (clk_i),
    .ce_i  (ce),
    .num_i (m1_q),
    .den_i (den_q),
    .quo_o (quo1)
  );

  qrs_div_pipe #(
    .NUM_W (NW),
    .DEN_W (W + 1)
  ) u_div_second (
    .clk_i (clk_i),
    .ce_i  (ce),
    .num_i (m2_q),
    .den_i (den_q),
    .quo_o (quo2)
  );

  always_ff @(posedge clk_i) begin
    if (ce) begin
      dv_side_q[0] <= num_side_q;
      for (int k = 1; k < XW; k++) begin
        dv_side_q[k] <= dv_side_q[k-1];
      end
    end
  end

  // ---- output stage ----
  root_kind_e kind_f;
  root_res_t  res1, res2;
  logic       has_roots;

  assign kind_f    = root_kind_e'(dv_side_q[XW-1][3:2]);
  assign res1      = clip_root(QUO_EXT_W'(quo1), dv_side_q[XW-1][1]);
  assign res2      = clip_root(QUO_EXT_W'(quo2), dv_side_q[XW-1][0]);
  assign has_roots = (kind_f == KIND_TWO) || (kind_f == KIND_DOUBLE);

  logic [1:0]           kind_o_q;
  logic [OUT_WIDTH-1:0] r1_q, r2_q;
  logic                 sat_q;

  always_ff @(posedge clk_i) begin
    if (out_ld) begin
      kind_o_q <= kind_f;
      r1_q     <= has_roots ? res1.value : '0;
      r2_q     <= has_roots ? res2.value : '0;
      sat_q    <= has_roots & (res1.sat | res2.sat);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign root_kind_o   = kind_o_q;
  assign root_first_o  = $signed(r1_q);
  assign root_second_o = $signed(r2_q);
  assign saturated_o   = sat_q;

`ifndef SYNTH
  a_no_roots_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (root_kind_o == KIND_NONE || root_kind_o == KIND_DEGEN)
      |-> root_first_o == '0 && root_second_o == '0 && !saturated_o)
    else $error("roots not cleared for a no-root word");

  a_double_equal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && root_kind_o == KIND_DOUBLE |-> root_first_o == root_second_o)
    else $error("double root halves differ");

  a_sat_clipped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o
      |-> root_first_o == 32'sh7FFF_FFFF || root_first_o == 32'sh8000_0000
       || root_second_o == 32'sh7FFF_FFFF || root_second_o == 32'sh8000_0000)
    else $error("saturated flag without a clipped root");
`endif

endmodule
